### src/yuv422_row_to_rgb565_top_assert.svh
// ----------------------------------------------------------------------------
// YUV422 to RGB565 converter - assertion macros
// Clocked implication macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef YUV422_ROW_TO_RGB565_TOP_ASSERT_SVH
`define YUV422_ROW_TO_RGB565_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define YRGB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("yuv422_row_to_rgb565: same-cycle check failed");

// next-cycle implication, off during reset
`define YRGB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("yuv422_row_to_rgb565: next-cycle check failed");

`endif

### src/yrgb_pkg.sv
// ----------------------------------------------------------------------------
// YUV422 to RGB565 converter - package
// Register map, output format codes and conversion constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package yrgb_pkg;

    // register word index (paddr[3:2])
    localparam logic [1:0] REG_OUT_FORMAT   = 2'd0;
    localparam logic [1:0] REG_CHROMA_ORDER = 2'd1;
    localparam logic [1:0] REG_ROW_WIDTH    = 2'd2;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // out_format codes
    localparam logic [1:0] FMT_BINARY = 2'd0;
    localparam logic [1:0] FMT_GRAY   = 2'd1;
    localparam logic [1:0] FMT_RGB565 = 2'd2;

    localparam logic ORDER_YUV = 1'b0;

    localparam int              ROW_WIDTH_W     = 13;
    localparam logic [12:0]     ROW_WIDTH_RESET = 13'd320;
    localparam logic [7:0]      CHROMA_NEUTRAL  = 8'h80;

    // fixed-point color terms, scaled by 128
    localparam logic signed [16:0] COEF_RV = 17'sd179;
    localparam logic signed [16:0] COEF_GV = 17'sd91;
    localparam logic signed [16:0] COEF_GU = 17'sd44;
    localparam logic signed [16:0] COEF_BU = 17'sd227;

endpackage

### src/yuv422_row_to_rgb565_top.sv
// ----------------------------------------------------------------------------
// YUV422 row to RGB565 converter - top level
// Converts one packed YUV422 pixel pair per word into two binary, gray or
// RGB565 pixels, tracking row position for odd row widths.
// ----------------------------------------------------------------------------
// Usage: one pixel-pair word is taken every clock and its result comes out
// through the input register, then the result register; the rate of one
// word per cycle holds as long as the output side does not stall. Program
// out_format, chroma_order and row_width over APB only while the block is
// empty. A row of odd width ends with a lone pixel (second_valid low) that
// borrows the odd chroma of the previous pair; a one-pixel row uses neutral
// chroma. row_width 0 acts as 1 and widths above MAX_WIDTH are clipped.
`timescale 1ns / 1ps

module yuv422_row_to_rgb565_top
    import yrgb_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // APB configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready,
    // input words
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           luma_even,
    input  logic [7:0]           chroma_even,
    input  logic [7:0]           luma_odd,
    input  logic [7:0]           chroma_odd,
    // output words
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [15:0]          pixel_first,
    output logic [15:0]          pixel_second,
    output logic                 second_valid,
    output logic                 row_end
);

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = (WW > ROW_WIDTH_W) ? WW : ROW_WIDTH_W;

    // configuration
    logic [1:0]             out_format_reg;
    logic                   chroma_order_reg;
    logic [ROW_WIDTH_W-1:0] row_width_reg;
    logic                   cfg_write;

    // row tracking
    logic [WW-1:0]          column_reg;
    logic [WW-1:0]          column_next;
    logic [7:0]             prior_reg;
    logic [7:0]             prior_next;

    // input stage
    logic                   s1_valid_reg;
    logic [7:0]             s1_y0_reg;
    logic [7:0]             s1_y1_reg;
    logic [7:0]             s1_c0_reg;
    logic [7:0]             s1_c1_reg;
    logic                   s1_lone_reg;
    logic                   s1_end_reg;

    // result stage
    logic                   out_valid_reg;
    logic [15:0]            pix0_reg;
    logic [15:0]            pix1_reg;
    logic                   second_reg;
    logic                   end_reg;

    logic                   out_free;
    logic                   s1_free;
    logic                   in_accept;

    logic [CMP_W-1:0]       rw_ext;
    logic [CMP_W-1:0]       w_cmp;
    logic [WW-1:0]          w_eff;
    logic [WW-1:0]          col_eff;
    logic [WW:0]            col_sum;
    logic                   single;
    logic                   lone;
    logic                   end_pair;
    logic [7:0]             c0_sel;
    logic [7:0]             c1_sel;

    logic signed [7:0]      s0;
    logic signed [7:0]      s1;
    logic signed [7:0]      u;
    logic signed [7:0]      v;
    logic signed [16:0]     ry_prod;
    logic signed [16:0]     gy_prod;
    logic signed [16:0]     by_prod;
    logic signed [10:0]     ry;
    logic signed [10:0]     gy;
    logic signed [10:0]     by;
    logic [15:0]            pix0_next;
    logic [15:0]            pix1_next;

    function automatic logic [7:0] sat8(input logic signed [10:0] val);
        logic [7:0] res;
        if (val < 0)
        begin
            res = 8'd0;
        end
        else if (val > 11'sd255)
        begin
            res = 8'd255;
        end
        else
        begin
            res = val[7:0];
        end
        return res;
    endfunction

    function automatic logic [15:0] convert(
        input logic [1:0]         fmt,
        input logic [7:0]         y,
        input logic signed [10:0] r_off,
        input logic signed [10:0] g_off,
        input logic signed [10:0] b_off
    );
        logic signed [10:0] y_s;
        logic [7:0]         r;
        logic [7:0]         g;
        logic [7:0]         b;
        logic [15:0]        res;
        y_s = signed'({3'b000, y});
        r   = sat8(y_s + r_off);
        g   = sat8(y_s - g_off);
        b   = sat8(y_s + b_off);
        unique case (fmt)
            FMT_BINARY: res = {15'd0, y[7]};
            FMT_GRAY:   res = {8'd0, y};
            FMT_RGB565: res = {r[7:3], g[7:2], b[7:3]};
            default:    res = 16'd0;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // APB registers
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_format_reg   <= FMT_RGB565;
            chroma_order_reg <= ORDER_YUV;
            row_width_reg    <= ROW_WIDTH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_OUT_FORMAT:   out_format_reg   <= pwdata[1:0];
                REG_CHROMA_ORDER: chroma_order_reg <= pwdata[0];
                REG_ROW_WIDTH:    row_width_reg    <= pwdata[ROW_WIDTH_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_OUT_FORMAT:   prdata = {30'd0, out_format_reg};
            REG_CHROMA_ORDER: prdata = {31'd0, chroma_order_reg};
            REG_ROW_WIDTH:    prdata = {{(PDATA_W-ROW_WIDTH_W){1'b0}}, row_width_reg};
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Flow control: the input stage moves when empty or when the output frees up
    // ------------------------------------------------------------------
    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_free   = !s1_valid_reg || out_free;
    assign in_stall  = !s1_free;
    assign in_accept = in_valid && s1_free;

    // ------------------------------------------------------------------
    // Row position and chroma selection
    // ------------------------------------------------------------------
    always_comb
    begin
        rw_ext = CMP_W'(row_width_reg);
        if (rw_ext == '0)
        begin
            w_cmp = CMP_W'(1);
        end
        else if (rw_ext > CMP_W'(MAX_WIDTH))
        begin
            w_cmp = CMP_W'(MAX_WIDTH);
        end
        else
        begin
            w_cmp = rw_ext;
        end
        w_eff = WW'(w_cmp);

        // width shrunk below the current column: start a new row
        col_eff  = (column_reg >= w_eff) ? '0 : column_reg;
        col_sum  = {1'b0, col_eff} + (WW+1)'(2);
        single   = (w_eff == WW'(1));
        lone     = (({1'b0, col_eff} + (WW+1)'(1)) == {1'b0, w_eff});
        end_pair = (col_sum >= {1'b0, w_eff});

        c0_sel = single ? CHROMA_NEUTRAL : chroma_even;
        if (!lone)
        begin
            c1_sel = chroma_odd;
        end
        else if (single)
        begin
            c1_sel = CHROMA_NEUTRAL;
        end
        else
        begin
            c1_sel = prior_reg;
        end

        column_next = (lone || end_pair) ? '0 : col_sum[WW-1:0];
        prior_next  = lone ? prior_reg : chroma_odd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg   <= '0;
            prior_reg    <= CHROMA_NEUTRAL;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                column_reg <= column_next;
                prior_reg  <= prior_next;
            end
            if (s1_free)
            begin
                s1_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_y0_reg   <= luma_even;
            s1_y1_reg   <= luma_odd;
            s1_c0_reg   <= c0_sel;
            s1_c1_reg   <= c1_sel;
            s1_lone_reg <= lone;
            s1_end_reg  <= lone || end_pair;
        end
    end

    // ------------------------------------------------------------------
    // Color conversion
    // ------------------------------------------------------------------
    always_comb
    begin
        s0 = signed'(s1_c0_reg ^ CHROMA_NEUTRAL);
        s1 = signed'(s1_c1_reg ^ CHROMA_NEUTRAL);
        if (chroma_order_reg == ORDER_YUV)
        begin
            u = s0;
            v = s1;
        end
        else
        begin
            u = s1;
            v = s0;
        end

        ry_prod = COEF_RV * 17'(v);
        gy_prod = (COEF_GU * 17'(u)) + (COEF_GV * 17'(v));
        by_prod = COEF_BU * 17'(u);

        // arithmetic shift gives floor division by 128
        ry = 11'(ry_prod >>> 7);
        gy = 11'(gy_prod >>> 7);
        by = 11'(by_prod >>> 7);

        pix0_next = convert(out_format_reg, s1_y0_reg, ry, gy, by);
        pix1_next = s1_lone_reg ? 16'd0 : convert(out_format_reg, s1_y1_reg, ry, gy, by);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg)
        begin
            pix0_reg   <= pix0_next;
            pix1_reg   <= pix1_next;
            second_reg <= !s1_lone_reg;
            end_reg    <= s1_end_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_first  = pix0_reg;
    assign pixel_second = pix1_reg;
    assign second_valid = second_reg;
    assign row_end      = end_reg;

endmodule

### src/yrgb_checker.sv
// ----------------------------------------------------------------------------
// YUV422 to RGB565 converter - port checker
// Watches the top-level ports for row and flow-control consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "yuv422_row_to_rgb565_top_assert.svh"

module yrgb_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] pixel_first,
    input logic [15:0] pixel_second,
    input logic        second_valid,
    input logic        row_end
);

    // a lone pixel always closes its row
    `YRGB_ASSERT_NOW(a_lone_ends_row, clk, rst_n, out_valid && !second_valid, row_end)

    // a missing second pixel reads as zero
    `YRGB_ASSERT_NOW(a_lone_second_zero, clk, rst_n, out_valid && !second_valid,
                     pixel_second == 16'd0)

    // input never stalls while the output register is empty
    `YRGB_ASSERT_NOW(a_no_stall_when_empty, clk, rst_n, in_valid && !out_valid, !in_stall)

    // a stalled output word holds
    `YRGB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                      out_valid && $stable(pixel_first) && $stable(row_end))

endmodule

bind yuv422_row_to_rgb565_top yrgb_checker u_yrgb_checker (.*);
